// ===== rtl/rhaf_pkg.sv =====
// Shared types, constants and helpers for the rolling hash anchor finder.
// Holds the two hash ROMs, built at elaboration from fixed seeds.
// No dependencies.
`timescale 1ns / 1ps

package rhaf_pkg;

  localparam logic [63:0] SEED_PRIMARY   = 64'h46a7_c15d_3b92_e801;
  localparam logic [63:0] SEED_SECONDARY = 64'hd1b5_4a32_d192_ed03;
  localparam logic [63:0] MIX_STEP       = 64'h9e37_79b9_7f4a_7c15;
  localparam logic [63:0] MIX_MUL_A      = 64'hbf58_476d_1ce4_e5b9;
  localparam logic [63:0] MIX_MUL_B      = 64'h94d0_49bb_1331_11eb;

  localparam int unsigned ROM_DEPTH = 256;

  // APB register map: 64-bit registers at 8-byte spacing
  localparam int unsigned PADDR_W  = 4;
  localparam logic        REG_MASK = 1'b0;
  localparam logic [63:0] MASK_RST = 64'd63;

  typedef logic [63:0] rom_t [ROM_DEPTH];

  // Lookup stage -> hash stage
  typedef struct packed {
    logic        valid;
    logic        clear;   // first byte of a stream: start from a zero hash
    logic        remove;  // window was full: xor out the leaving byte
    logic        full;
    logic [31:0] wstart;
    logic [63:0] p_new;
    logic [63:0] p_old;
    logic [63:0] s_new;
    logic [63:0] s_old;
  } rhaf_stage_t;

  function automatic logic [63:0] mix64(input logic [63:0] x);
    logic [63:0] z;
    z = x;
    z = (z ^ (z >> 30)) * MIX_MUL_A;
    z = (z ^ (z >> 27)) * MIX_MUL_B;
    return z ^ (z >> 31);
  endfunction

  // Elaboration only: entry i is the (i+1)-th generator output
  function automatic rom_t build_rom(input logic [63:0] seed);
    rom_t        rom;
    logic [63:0] st;
    st = seed;
    for (int i = 0; i < ROM_DEPTH; i++) begin
      st     = st + MIX_STEP;
      rom[i] = mix64(st);
    end
    return rom;
  endfunction

  function automatic logic [63:0] rotl64(input logic [63:0] v, input logic [5:0] s);
    logic [127:0] w;
    w = {v, v} << s;
    return w[127:64];
  endfunction

  localparam rom_t ROM_PRIMARY   = build_rom(SEED_PRIMARY);
  localparam rom_t ROM_SECONDARY = build_rom(SEED_SECONDARY);

endpackage

// ===== rtl/rhaf_lookup.sv =====
// Lookup stage: window byte line, fill and position tracking, ROM reads.
// Depends on rhaf_pkg.
`timescale 1ns / 1ps

module rhaf_lookup
  import rhaf_pkg::*;
#(
  parameter int unsigned WINDOW = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        stream_start_i,
  input  logic [7:0]  data_byte_i,
  input  logic        take_i,
  output rhaf_stage_t stage_o
);

  localparam int unsigned FILL_W   = $clog2(WINDOW + 1);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(WINDOW);
  localparam logic [5:0]  ROT      = 6'(WINDOW % 64);
  localparam logic [31:0] WIN32    = 32'(WINDOW);

  logic [7:0]        line_q [WINDOW];
  logic [FILL_W-1:0] fill_q, fill_d, fill_base;
  logic [31:0]       pos_q, pos_d, pos_base;
  logic              in_fire, remove, full;
  logic [7:0]        old_byte;
  logic              stage_valid_q;
  rhaf_stage_t       stage_q, stage_d;

  assign in_ready_o = !stage_valid_q || take_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign old_byte   = line_q[WINDOW-1];

  always_comb begin
    fill_base = stream_start_i ? '0 : fill_q;
    pos_base  = stream_start_i ? '0 : pos_q;
    remove    = (fill_base == FILL_MAX);
    fill_d    = remove ? fill_base : fill_base + 1'b1;
    full      = (fill_d == FILL_MAX);
    pos_d     = pos_base + 32'd1;

    stage_d.valid  = 1'b1;
    stage_d.clear  = stream_start_i;
    stage_d.remove = remove;
    stage_d.full   = full;
    stage_d.wstart = full ? pos_d - WIN32 : '0;
    stage_d.p_new  = ROM_PRIMARY[data_byte_i];
    stage_d.s_new  = ROM_SECONDARY[data_byte_i];
    stage_d.p_old  = rotl64(ROM_PRIMARY[old_byte], ROT);
    stage_d.s_old  = rotl64(ROM_SECONDARY[old_byte], ROT);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q        <= '0;
      pos_q         <= '0;
      stage_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        fill_q <= fill_d;
        pos_q  <= pos_d;
      end
      if (in_fire) begin
        stage_valid_q <= 1'b1;
      end else if (take_i) begin
        stage_valid_q <= 1'b0;
      end
    end
  end

  // payload and byte line, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      stage_q   <= stage_d;
      line_q[0] <= data_byte_i;
      for (int i = 1; i < WINDOW; i++) begin
        line_q[i] <= line_q[i-1];
      end
    end
  end

  always_comb begin
    stage_o       = stage_q;
    stage_o.valid = stage_valid_q;
  end

endmodule

// ===== rtl/rolling_hash_anchor_finder_unit.sv =====
// Top level of the rolling hash anchor finder: APB mask register, hash stage.
// Depends on rhaf_pkg and rhaf_lookup.
`timescale 1ns / 1ps
//
//  channel  | handshake              | payload
//  ---------+------------------------+-----------------------------------------
//  in       | in_valid_i/in_ready_o  | stream_start_i, data_byte_i
//  out      | out_valid_o/out_ready_i| window_full_o, is_anchor_o, hash_primary_o,
//           |                        | hash_secondary_o, window_start_o
//  cfg      | APB psel/penable       | anchor_mask at byte address 0 (64 bit)
//
//  One beat per cycle sustained while the output is not stalled.
//  Stage one reads both ROMs for the new and leaving byte; stage two does the
//  rotate-xor against the stored hash, so that feedback loop sets the rate.
//  Reset clears hashes, fill count, position and valids; mask resets to 63.
//  A stalled output holds its beat and stalls the lookup stage behind it.

module rolling_hash_anchor_finder_unit
  import rhaf_pkg::*;
#(
  parameter int unsigned WINDOW = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               stream_start_i,
  input  logic [7:0]         data_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               window_full_o,
  output logic               is_anchor_o,
  output logic [63:0]        hash_primary_o,
  output logic [63:0]        hash_secondary_o,
  output logic [31:0]        window_start_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);

  rhaf_stage_t stage;
  logic        take, fire;
  logic [63:0] anchor_mask_q;
  logic [63:0] hash_p_q, hash_p_d, hash_s_q, hash_s_d;
  logic        out_valid_q, full_q, anchor_q, anchor_d;
  logic [31:0] wstart_q;

  assign take = !out_valid_q || out_ready_i;
  assign fire = stage.valid && take;

  rhaf_lookup #(
    .WINDOW(WINDOW)
  ) u_lookup (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .stream_start_i(stream_start_i),
    .data_byte_i   (data_byte_i),
    .take_i        (take),
    .stage_o       (stage)
  );

  // config register
  assign pready = 1'b1;
  assign prdata = (paddr[PADDR_W-1] == REG_MASK) ? anchor_mask_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      anchor_mask_q <= MASK_RST;
    end else if (psel && penable && pwrite && paddr[PADDR_W-1] == REG_MASK) begin
      anchor_mask_q <= pwdata;
    end
  end

  always_comb begin
    hash_p_d = rotl64(stage.clear ? '0 : hash_p_q, 6'd1) ^ stage.p_new
               ^ (stage.remove ? stage.p_old : '0);
    hash_s_d = rotl64(stage.clear ? '0 : hash_s_q, 6'd1) ^ stage.s_new
               ^ (stage.remove ? stage.s_old : '0);
    anchor_d = stage.full && ((hash_p_d & anchor_mask_q) == '0);
  end

  // hash registers are both running state and output beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      hash_p_q    <= '0;
      hash_s_q    <= '0;
    end else begin
      if (take) begin
        out_valid_q <= stage.valid;
      end
      if (fire) begin
        hash_p_q <= hash_p_d;
        hash_s_q <= hash_s_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      full_q   <= stage.full;
      anchor_q <= anchor_d;
      wstart_q <= stage.wstart;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign window_full_o    = full_q;
  assign is_anchor_o      = anchor_q;
  assign hash_primary_o   = hash_p_q;
  assign hash_secondary_o = hash_s_q;
  assign window_start_o   = wstart_q;

`ifndef SYNTHESIS
  a_anchor_needs_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_anchor_o |-> window_full_o)
    else $error("anchor flagged on a partial window");

  a_start_zero_when_filling: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !window_full_o |-> window_start_o == '0)
    else $error("window start set while window not full");

  a_anchor_matches_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && window_full_o |->
      is_anchor_o == ((hash_primary_o & anchor_mask_q) == '0))
    else $error("anchor flag disagrees with masked hash");

  a_stall_from_output_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output backpressure");
`endif

endmodule
